[design/cec_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and calendar helper functions for the calendar epoch converter.
// No dependencies; every other design file refers to this package by scoped names.
package cec_pkg;

	localparam logic [1:0] ACT_TO_SECS  = 2'd0;
	localparam logic [1:0] ACT_TO_DATE  = 2'd1;
	localparam logic [1:0] ACT_ADVANCE  = 2'd2;
	localparam logic [1:0] ACT_RESERVED = 2'd3;

	localparam logic [16:0] DAY_SECS   = 17'd86400;
	// reciprocals, exact over the value ranges they see here
	localparam logic [25:0] RECIP_675  = 26'd50903317; // >> 35
	localparam logic [15:0] RECIP_365  = 16'd45965;    // >> 24
	localparam logic [16:0] RECIP_3600 = 17'd74566;    // >> 28
	localparam logic [12:0] RECIP_60   = 13'd4370;     // >> 18
	localparam logic [12:0] RECIP_100  = 13'd5243;     // >> 19, >> 21 for 400

	typedef struct packed {
		logic [1:0]         action;
		logic [11:0]        year;
		logic [3:0]         month;
		logic [4:0]         day_of_month;
		logic [5:0]         hour;
		logic [5:0]         minute;
		logic [5:0]         second;
		logic [31:0]        seconds_count;
		logic signed [31:0] delta_seconds;
	} item_t;

	typedef struct packed {
		logic        status;
		logic [31:0] out_seconds;
		logic [11:0] out_year;
		logic [3:0]  out_month;
		logic [4:0]  out_day_of_month;
		logic [8:0]  out_day_of_year;
		logic [4:0]  out_hour;
		logic [5:0]  out_minute;
		logic [5:0]  out_second;
	} result_t;

	// seconds count handed from the encode half to the decode half
	typedef struct packed {
		logic        ok;
		logic [31:0] secs;
	} enc_t;

	function automatic logic [12:0] div100(input logic [13:0] x);
		logic [26:0] p;
		p = 27'(x) * 27'(RECIP_100);
		return 13'(p >> 19);
	endfunction

	function automatic logic [12:0] div400(input logic [13:0] x);
		logic [26:0] p;
		p = 27'(x) * 27'(RECIP_100);
		return 13'(p >> 21);
	endfunction

	// leap years in 0 .. y-1
	function automatic logic [10:0] leaps_below(input logic [12:0] y);
		logic [13:0] a;
		logic [13:0] b;
		logic [13:0] c;
		a = 14'(y) + 14'd3;
		b = 14'(y) + 14'd99;
		c = 14'(y) + 14'd399;
		return 11'((a >> 2) - 14'(div100(b)) + 14'(div400(c)));
	endfunction

	function automatic logic is_leap(input logic [12:0] y);
		logic [12:0] q100;
		logic [12:0] q400;
		logic [13:0] r100;
		logic [13:0] r400;
		q100 = div100(14'(y));
		q400 = div400(14'(y));
		r100 = 14'(14'(y) - 14'(21'(q100) * 21'd100));
		r400 = 14'(14'(y) - 14'(22'(q400) * 22'd400));
		return (r400 == 14'd0) || ((r100 != 14'd0) && (y[1:0] == 2'b00));
	endfunction

	function automatic logic [8:0] days_before_month(input logic [3:0] m);
		logic [8:0] d;
		unique case (m)
			4'd1:    d = 9'd0;
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m);
		logic [4:0] l;
		unique case (m)
			4'd2:                      l = 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   l = 5'd30;
			4'd1, 4'd3, 4'd5, 4'd7,
			4'd8, 4'd10, 4'd12:        l = 5'd31;
			default:                   l = 5'd0;
		endcase
		return l;
	endfunction

	// zero-based day of year of the first of month m
	function automatic logic [8:0] month_first(input logic [3:0] m, input logic leap);
		return days_before_month(m) + ((leap && m > 4'd2) ? 9'd1 : 9'd0);
	endfunction

endpackage

[design/cec_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for items and results.
// Depends on cec_pkg for the payload types.
interface cec_item_if;
	logic           valid;
	logic           ready;
	cec_pkg::item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface cec_result_if;
	logic             valid;
	logic             ready;
	cec_pkg::result_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[design/calendar_epoch_converter_unit.sv]
`timescale 1ns / 1ps
// Top level of the calendar epoch converter: encode half followed by decode half.
// Depends on cec_pkg, cec_if, cec_encode and cec_decode.
//
//   channel | role   | payload            | transfer when
//   --------+--------+--------------------+----------------------
//   req     | sink   | cec_pkg::item_t    | req.valid && req.ready
//   rsp     | source | cec_pkg::result_t  | rsp.valid && rsp.ready
//
// One item enters per cycle while req.ready is high; each result passes through
// four encode stages and six decode stages.
// Reset clears only the stage valid bits; there is no other state.
// Each stage holds while the one after it is full and stalled, so bubbles close up
// and req.ready stays high as long as any stage has room.
module calendar_epoch_converter_unit #(
	parameter int EPOCH_YEAR = 1970,
	parameter int LAST_YEAR = 2105
) (
	input logic          clk,
	input logic          arst_n,
	cec_item_if.sink     req,
	cec_result_if.source rsp
);

	// seconds count and its range status between the two halves
	cec_pkg::enc_t mid_data;
	logic          mid_valid;
	logic          mid_ready;

	// validate the date, form seconds, apply the signed offset
	cec_encode #(
		.EPOCH_YEAR(EPOCH_YEAR),
		.LAST_YEAR(LAST_YEAR)
	) u_encode (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.in_data  (req.data),
		.out_valid(mid_valid),
		.out_ready(mid_ready),
		.out_data (mid_data)
	);

	// split seconds back into calendar fields; drop to the failure result on error
	cec_decode #(
		.EPOCH_YEAR(EPOCH_YEAR),
		.LAST_YEAR(LAST_YEAR)
	) u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (mid_valid),
		.in_ready (mid_ready),
		.in_data  (mid_data),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.out_data (rsp.data)
	);

endmodule

[design/cec_encode.sv]
`timescale 1ns / 1ps
// Four-stage front half: checks the date and time, turns it into seconds, applies the offset.
// Depends on cec_pkg. Offset for ACT_ADVANCE only; ACT_TO_DATE passes seconds_count through.
module cec_encode #(
	parameter int EPOCH_YEAR = 1970,
	parameter int LAST_YEAR = 2105
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  cec_pkg::item_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output cec_pkg::enc_t  out_data
);

	localparam logic [10:0] LB_BASE = cec_pkg::leaps_below(13'(EPOCH_YEAR));
	localparam logic [11:0] BASE_Y  = 12'(EPOCH_YEAR);
	localparam logic [11:0] LAST_Y  = 12'(LAST_YEAR);

	typedef struct packed {
		logic [1:0]         action;
		logic               enc_ok;
		logic [11:0]        ydiff;
		logic [10:0]        lb;
		logic [8:0]         dayoff;
		logic [16:0]        tod;
		logic [31:0]        sc;
		logic signed [31:0] delta;
	} s1_t;

	typedef struct packed {
		logic [1:0]         action;
		logic               enc_ok;
		logic [20:0]        days;
		logic [16:0]        tod;
		logic [31:0]        sc;
		logic signed [31:0] delta;
	} s2_t;

	typedef struct packed {
		logic [1:0]         action;
		logic               enc_ok;
		logic [38:0]        esec;
		logic [31:0]        sc;
		logic signed [31:0] delta;
	} s3_t;

	s1_t d1, r_s1;
	s2_t d2, r_s2;
	s3_t d3, r_s3;
	cec_pkg::enc_t d4, r_s4;
	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;
	logic leap;
	logic [4:0] mlen;
	logic fits;
	logic signed [39:0] sum;

	assign en4      = !v_s4 || out_ready;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;
	assign out_valid = v_s4;
	assign out_data  = r_s4;

	always_comb begin
		leap = cec_pkg::is_leap({1'b0, in_data.year});
		mlen = cec_pkg::month_len(in_data.month)
			+ ((in_data.month == 4'd2 && leap) ? 5'd1 : 5'd0);
		d1.action = in_data.action;
		d1.enc_ok = (in_data.year >= BASE_Y) && (in_data.year <= LAST_Y)
			&& (in_data.month >= 4'd1) && (in_data.month <= 4'd12)
			&& (in_data.day_of_month >= 5'd1) && (in_data.day_of_month <= mlen)
			&& (in_data.hour < 6'd24) && (in_data.minute < 6'd60)
			&& (in_data.second < 6'd60);
		d1.ydiff  = in_data.year - BASE_Y;
		d1.lb     = cec_pkg::leaps_below({1'b0, in_data.year});
		d1.dayoff = cec_pkg::month_first(in_data.month, leap)
			+ 9'(in_data.day_of_month - 5'd1);
		d1.tod    = 17'(18'(in_data.hour) * 18'd3600 + 18'(in_data.minute) * 18'd60
			+ 18'(in_data.second));
		d1.sc     = in_data.seconds_count;
		d1.delta  = in_data.delta_seconds;
	end

	always_comb begin
		d2.action = r_s1.action;
		d2.enc_ok = r_s1.enc_ok;
		d2.days   = 21'(23'(r_s1.ydiff) * 23'd365 + 23'(r_s1.lb) - 23'(LB_BASE)
			+ 23'(r_s1.dayoff));
		d2.tod    = r_s1.tod;
		d2.sc     = r_s1.sc;
		d2.delta  = r_s1.delta;
	end

	always_comb begin
		d3.action = r_s2.action;
		d3.enc_ok = r_s2.enc_ok;
		d3.esec   = 39'(r_s2.days) * 39'(cec_pkg::DAY_SECS) + 39'(r_s2.tod);
		d3.sc     = r_s2.sc;
		d3.delta  = r_s2.delta;
	end

	always_comb begin
		fits = (r_s3.esec[38:32] == 7'd0);
		sum  = $signed({1'b0, r_s3.esec}) + 40'(r_s3.delta);
		d4.ok   = 1'b0;
		d4.secs = r_s3.sc;
		unique case (r_s3.action)
			cec_pkg::ACT_TO_SECS: begin
				d4.ok   = r_s3.enc_ok && fits;
				d4.secs = r_s3.esec[31:0];
			end
			cec_pkg::ACT_TO_DATE: begin
				d4.ok   = 1'b1;
				d4.secs = r_s3.sc;
			end
			cec_pkg::ACT_ADVANCE: begin
				d4.ok   = r_s3.enc_ok && fits && (sum[39:32] == 8'd0);
				d4.secs = sum[31:0];
			end
			default: begin
				d4.ok   = 1'b0;
				d4.secs = r_s3.sc;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) r_s1 <= d1;
		if (en2) r_s2 <= d2;
		if (en3) r_s3 <= d3;
		if (en4) r_s4 <= d4;
	end

endmodule

[design/cec_decode.sv]
`timescale 1ns / 1ps
// Six-stage back half: splits a seconds count into year, month, day and time of day.
// Depends on cec_pkg.
module cec_decode #(
	parameter int EPOCH_YEAR = 1970,
	parameter int LAST_YEAR = 2105
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  cec_pkg::enc_t    in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output cec_pkg::result_t out_data
);

	localparam logic [10:0] LB_BASE = cec_pkg::leaps_below(13'(EPOCH_YEAR));

	typedef struct packed {
		logic        ok;
		logic [31:0] secs;
		logic [15:0] days;
	} s1_t;

	typedef struct packed {
		logic        ok;
		logic [31:0] secs;
		logic [15:0] days;
		logic [16:0] rem;
		logic [7:0]  kest;
		logic [12:0] y0;
	} s2_t;

	typedef struct packed {
		logic        ok;
		logic [31:0] secs;
		logic [15:0] days;
		logic [16:0] rem;
		logic [7:0]  kest;
		logic [12:0] y0;
		logic [10:0] lb0;
		logic [10:0] lb1;
		logic        leap0;
		logic        leap1;
		logic [4:0]  hour;
	} s3_t;

	typedef struct packed {
		logic        ok;
		logic [31:0] secs;
		logic [12:0] year;
		logic        leap;
		logic [8:0]  doy;
		logic [4:0]  hour;
		logic [11:0] rem2;
	} s4_t;

	typedef struct packed {
		logic        ok;
		logic [31:0] secs;
		logic [12:0] year;
		logic [3:0]  month;
		logic [8:0]  first;
		logic [8:0]  doy;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [11:0] rem2;
	} s5_t;

	s1_t d1, r_s1;
	s2_t d2, r_s2;
	s3_t d3, r_s3;
	s4_t d4, r_s4;
	s5_t d5, r_s5;
	cec_pkg::result_t d6, r_s6;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;
	logic [50:0] p_day;
	logic [32:0] p_rem;
	logic [31:0] p_year;
	logic [33:0] p_hour;
	logic [24:0] p_min;
	logic [16:0] ys_hi;
	logic [16:0] ys_lo;
	logic [16:0] ys;
	logic        sel_lo;

	assign en6       = !v_s6 || out_ready;
	assign en5       = !v_s5 || en6;
	assign en4       = !v_s4 || en5;
	assign en3       = !v_s3 || en4;
	assign en2       = !v_s2 || en3;
	assign en1       = !v_s1 || en2;
	assign in_ready  = en1;
	assign out_valid = v_s6;
	assign out_data  = r_s6;

	// whole days: drop the factor 128 of 86400, then divide by 675
	always_comb begin
		p_day   = 51'(in_data.secs[31:7]) * 51'(cec_pkg::RECIP_675);
		d1.ok   = in_data.ok;
		d1.secs = in_data.secs;
		d1.days = p_day[50:35];
	end

	// second of day, and a year estimate that is at most one too high
	always_comb begin
		p_rem   = 33'(r_s1.days) * 33'(cec_pkg::DAY_SECS);
		p_year  = 32'(r_s1.days) * 32'(cec_pkg::RECIP_365);
		d2.ok   = r_s1.ok;
		d2.secs = r_s1.secs;
		d2.days = r_s1.days;
		d2.rem  = 17'(33'(r_s1.secs) - p_rem);
		d2.kest = p_year[31:24];
		d2.y0   = 13'(EPOCH_YEAR) + 13'(p_year[31:24]);
	end

	always_comb begin
		p_hour   = 34'(r_s2.rem) * 34'(cec_pkg::RECIP_3600);
		d3.ok    = r_s2.ok;
		d3.secs  = r_s2.secs;
		d3.days  = r_s2.days;
		d3.rem   = r_s2.rem;
		d3.kest  = r_s2.kest;
		d3.y0    = r_s2.y0;
		d3.lb0   = cec_pkg::leaps_below(r_s2.y0);
		d3.lb1   = cec_pkg::leaps_below(r_s2.y0 - 13'd1);
		d3.leap0 = cec_pkg::is_leap(r_s2.y0);
		d3.leap1 = cec_pkg::is_leap(r_s2.y0 - 13'd1);
		d3.hour  = p_hour[32:28];
	end

	// step back one year if the estimate starts after the day count
	always_comb begin
		ys_hi  = 17'(17'(r_s3.kest) * 17'd365 + 17'(r_s3.lb0) - 17'(LB_BASE));
		ys_lo  = 17'(17'(r_s3.kest - 8'd1) * 17'd365 + 17'(r_s3.lb1) - 17'(LB_BASE));
		sel_lo = (r_s3.kest != 8'd0) && (ys_hi > 17'(r_s3.days));
		ys     = sel_lo ? ys_lo : ys_hi;
		d4.year = sel_lo ? (r_s3.y0 - 13'd1) : r_s3.y0;
		d4.leap = sel_lo ? r_s3.leap1 : r_s3.leap0;
		d4.ok   = r_s3.ok && (d4.year <= 13'(LAST_YEAR));
		d4.secs = r_s3.secs;
		d4.doy  = 9'(17'(r_s3.days) - ys);
		d4.hour = r_s3.hour;
		d4.rem2 = 12'(r_s3.rem - 17'(r_s3.hour) * 17'd3600);
	end

	always_comb begin
		p_min    = 25'(r_s4.rem2) * 25'(cec_pkg::RECIP_60);
		d5.month = 4'd1;
		for (int i = 2; i <= 12; i++) begin
			if (r_s4.doy >= cec_pkg::month_first(4'(i), r_s4.leap)) d5.month = 4'(i);
		end
		d5.first  = cec_pkg::month_first(d5.month, r_s4.leap);
		d5.ok     = r_s4.ok;
		d5.secs   = r_s4.secs;
		d5.year   = r_s4.year;
		d5.doy    = r_s4.doy;
		d5.hour   = r_s4.hour;
		d5.minute = p_min[23:18];
		d5.rem2   = r_s4.rem2;
	end

	always_comb begin
		d6.status           = 1'b0;
		d6.out_seconds      = r_s5.secs;
		d6.out_year         = r_s5.year[11:0];
		d6.out_month        = r_s5.month;
		d6.out_day_of_month = 5'(r_s5.doy - r_s5.first + 9'd1);
		d6.out_day_of_year  = r_s5.doy + 9'd1;
		d6.out_hour         = r_s5.hour;
		d6.out_minute       = r_s5.minute;
		d6.out_second       = 6'(r_s5.rem2 - 12'(r_s5.minute) * 12'd60);
		if (!r_s5.ok) begin
			d6        = '0;
			d6.status = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) r_s1 <= d1;
		if (en2) r_s2 <= d2;
		if (en3) r_s3 <= d3;
		if (en4) r_s4 <= d4;
		if (en5) r_s5 <= d5;
		if (en6) r_s6 <= d6;
	end

endmodule

[tb/calendar_epoch_converter_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for calendar_epoch_converter_unit: directed and random conversions.
// Depends on cec_pkg, cec_if and the block itself; predicts every result internally.

class epoch_scoreboard;
	cec_pkg::result_t pending_q[$];
	int errors;

	function bit leap(int y);
		return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
	endfunction

	function longint year_days(int y);
		int k;
		longint d;
		d = 0;
		for (k = 1970; k < y; k++) d += leap(k) ? 366 : 365;
		return d;
	endfunction

	function int mfirst(int m, bit lp);
		int cum[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
		return cum[m - 1] + ((lp && m > 2) ? 1 : 0);
	endfunction

	// date and time to seconds; returns -1 on a bad field or a count past 32 bits
	function longint date_secs(cec_pkg::item_t it);
		int len;
		int lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		longint days;
		if (it.year < 1970 || it.year > 2105) return -1;
		if (it.month < 1 || it.month > 12) return -1;
		len = lens[it.month - 1] + ((it.month == 2 && leap(it.year)) ? 1 : 0);
		if (it.day_of_month < 1 || it.day_of_month > len) return -1;
		if (it.hour >= 24 || it.minute >= 60 || it.second >= 60) return -1;
		days = year_days(it.year) + mfirst(it.month, leap(it.year)) + it.day_of_month - 1;
		days = days * 86400 + it.hour * 3600 + it.minute * 60 + it.second;
		if (days > 64'hFFFF_FFFF) return -1;
		return days;
	endfunction

	function cec_pkg::result_t secs_date(longint s);
		cec_pkg::result_t r;
		longint days, rem, doy;
		int y, m;
		r = '0;
		r.status = 1'b1;
		if (s < 0 || s > 64'hFFFF_FFFF) return r;
		days = s / 86400;
		rem = s % 86400;
		y = 1970;
		while (year_days(y + 1) <= days) y++;
		if (y > 2105) return r;
		doy = days - year_days(y);
		m = 12;
		while (m > 1 && doy < mfirst(m, leap(y))) m--;
		r.status = 1'b0;
		r.out_seconds = s[31:0];
		r.out_year = 12'(y);
		r.out_month = 4'(m);
		r.out_day_of_month = 5'(doy - mfirst(m, leap(y)) + 1);
		r.out_day_of_year = 9'(doy + 1);
		r.out_hour = 5'(rem / 3600);
		r.out_minute = 6'((rem % 3600) / 60);
		r.out_second = 6'(rem % 60);
		return r;
	endfunction

	function void note_item(cec_pkg::item_t it);
		longint s;
		cec_pkg::result_t r;
		r = '0;
		r.status = 1'b1;
		case (it.action)
			cec_pkg::ACT_TO_SECS: begin
				s = date_secs(it);
				if (s >= 0) r = secs_date(s);
			end
			cec_pkg::ACT_TO_DATE: r = secs_date(longint'(it.seconds_count));
			cec_pkg::ACT_ADVANCE: begin
				s = date_secs(it);
				if (s >= 0) r = secs_date(s + longint'(it.delta_seconds));
			end
			default: ;
		endcase
		pending_q.push_back(r);
	endfunction

	// count one mismatch, and print its line for the first 50 only
	task report(string what, cec_pkg::result_t want, cec_pkg::result_t got);
		errors++;
		if (errors <= 50)
			$display("MISMATCH %s: expected %0h got %0h at %0t", what, want, got,
				$realtime);
	endtask

	task check_result(cec_pkg::result_t got);
		cec_pkg::result_t exp_r;
		if (pending_q.size() == 0) begin
			report("result with nothing pending", '0, got);
			return;
		end
		exp_r = pending_q.pop_front();
		if (got !== exp_r) report("result", exp_r, got);
	endtask
endclass

module calendar_epoch_converter_unit_tb;

	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cec_item_if   req();
	cec_result_if rsp();

	calendar_epoch_converter_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	always #1 clk = ~clk;

	epoch_scoreboard sb = new();
	// idle and stall percentages per phase
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_off = 1'b0;
	int idle_cycles = 0;

	// note each item, check every result transfer, and count cycles with no transfer and no hold-off
	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready) sb.note_item(req.data);
			if (rsp.valid && rsp.ready) sb.check_result(rsp.data);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || hold_off)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// receiver side: random stalls, or a long hold-off when asked
	always @(negedge clk) begin
		if (!arst_n || hold_off) rsp.ready <= 1'b0;
		else rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// offer one item and hold it until the block takes it; valid stays up unless the next send idles
	task automatic send(cec_pkg::item_t it);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req.valid <= 1'b1;
		req.data <= it;
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
	endtask

	function automatic cec_pkg::item_t date_item(logic [1:0] act, int y, int mo, int d,
			int h, int mi, int s, logic [31:0] cnt, logic [31:0] dl);
		cec_pkg::item_t it;
		it.action = act;
		it.year = 12'(y);
		it.month = 4'(mo);
		it.day_of_month = 5'(d);
		it.hour = 6'(h);
		it.minute = 6'(mi);
		it.second = 6'(s);
		it.seconds_count = cnt;
		it.delta_seconds = dl;
		return it;
	endfunction

	// mostly valid dates; occasionally any field pattern at all
	function automatic cec_pkg::item_t random_item();
		cec_pkg::item_t it;
		logic [127:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom};
		it = raw[104:0];
		if ($urandom_range(9) < 8) begin
			it.year = ($urandom_range(3) == 0) ? 12'($urandom_range(2105, 2100))
				: 12'($urandom_range(2105, 1970));
			it.month = 4'($urandom_range(12, 1));
			it.day_of_month = 5'($urandom_range(31, 1));
			if (it.day_of_month > 28 && $urandom_range(1)) it.day_of_month = 5'd28;
			it.hour = 6'($urandom_range(23));
			it.minute = 6'($urandom_range(59));
			it.second = 6'($urandom_range(59));
			if ($urandom_range(3) == 0) it.delta_seconds = $signed($urandom_range(200000)) - 100000;
		end
		it.action = ($urandom_range(9) == 0) ? cec_pkg::ACT_RESERVED : 2'($urandom_range(2));
		return it;
	endfunction

	task automatic drain();
		while (sb.pending_q.size() != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	initial begin
		int n;
		req.valid <= 1'b0;
		req.data <= '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: field extremes, each action, epoch zero, span edges, leap days
		send(date_item(cec_pkg::ACT_TO_SECS, 1970, 1, 1, 0, 0, 0, 0, 0));
		send(date_item(cec_pkg::ACT_TO_SECS, 2105, 12, 31, 23, 59, 59, 0, 0));
		send(date_item(cec_pkg::ACT_TO_SECS, 2106, 1, 1, 0, 0, 0, 0, 0));
		send(date_item(cec_pkg::ACT_TO_SECS, 1969, 12, 31, 23, 59, 59, 0, 0));
		send(date_item(cec_pkg::ACT_TO_SECS, 2000, 2, 29, 12, 30, 30, 0, 0));
		send(date_item(cec_pkg::ACT_TO_SECS, 2100, 2, 29, 0, 0, 0, 0, 0));
		send(date_item(cec_pkg::ACT_TO_SECS, 2024, 0, 1, 0, 0, 0, 0, 0));
		send(date_item(cec_pkg::ACT_TO_SECS, 2024, 13, 1, 0, 0, 0, 0, 0));
		send(date_item(cec_pkg::ACT_TO_SECS, 2024, 4, 31, 0, 0, 0, 0, 0));
		send(date_item(cec_pkg::ACT_TO_SECS, 2024, 4, 0, 0, 0, 0, 0, 0));
		send(date_item(cec_pkg::ACT_TO_SECS, 2024, 4, 1, 24, 0, 0, 0, 0));
		send(date_item(cec_pkg::ACT_TO_SECS, 2024, 4, 1, 0, 60, 0, 0, 0));
		send(date_item(cec_pkg::ACT_TO_SECS, 4095, 15, 31, 63, 63, 63, 0, 0));
		send(date_item(cec_pkg::ACT_TO_DATE, 0, 0, 0, 0, 0, 0, 32'd0, 0));
		send(date_item(cec_pkg::ACT_TO_DATE, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 0));
		send(date_item(cec_pkg::ACT_TO_DATE, 0, 0, 0, 0, 0, 0, 32'd951782400, 0));
		send(date_item(cec_pkg::ACT_ADVANCE, 1970, 1, 1, 0, 0, 1, 0, 32'hFFFF_FFFF));
		send(date_item(cec_pkg::ACT_ADVANCE, 1970, 1, 1, 0, 0, 0, 0, 32'hFFFF_FFFF));
		send(date_item(cec_pkg::ACT_ADVANCE, 2105, 12, 31, 23, 59, 59, 0, 32'h7FFF_FFFF));
		send(date_item(cec_pkg::ACT_ADVANCE, 2038, 1, 19, 3, 14, 7, 0, 32'h8000_0000));
		send(date_item(cec_pkg::ACT_ADVANCE, 2099, 12, 31, 23, 59, 59, 0, 32'd1));
		send(date_item(cec_pkg::ACT_RESERVED, 2000, 1, 1, 0, 0, 0, 0, 0));

		// random phases: none, sender idle, receiver stall, both lightly
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1) ? 80 : (ph == 3) ? 7 : 0;
			recv_stall_pct = (ph == 2) ? 80 : (ph == 3) ? 7 : 0;
			for (n = 0; n < 375; n++) send(random_item());
			req.valid <= 1'b0;
			drain();
		end

		// long receiver hold-off while items keep coming, so the pipeline fills
		send_idle_pct = 0;
		recv_stall_pct = 0;
		fork
			begin
				hold_off = 1'b1;
				repeat (200) @(negedge clk);
				hold_off = 1'b0;
			end
			begin
				for (int k = 0; k < 40; k++) send(random_item());
				req.valid <= 1'b0;
			end
		join
		drain();

		if (sb.errors == 0 && sb.pending_q.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

[filelist.f]
design/cec_pkg.sv
design/cec_if.sv
design/cec_encode.sv
design/cec_decode.sv
design/calendar_epoch_converter_unit.sv
tb/calendar_epoch_converter_unit_tb.sv
